// File: src/iir3_pkg.sv
package iir3_pkg;

    localparam int SampleWidth = 16;
    localparam int CoefWidth   = 16;
    localparam int NumCoefs    = 7;
    localparam int ProdWidth   = SampleWidth + CoefWidth;
    localparam int QShift      = 14;
    localparam int MixShift    = 12;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDatWidth = 16;

    typedef logic signed [SampleWidth-1:0] sample_t;
    typedef logic signed [CoefWidth-1:0]   coef_t;
    typedef logic signed [ProdWidth-1:0]   prod_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_B3 = 3'd3,
        REG_A1 = 3'd4,
        REG_A2 = 3'd5,
        REG_A3 = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEL_B0  = 3'd0,
        SEL_B1  = 3'd1,
        SEL_B2  = 3'd2,
        SEL_B3  = 3'd3,
        SEL_A1  = 3'd4,
        SEL_A2  = 3'd5,
        SEL_A3  = 3'd6,
        SEL_MIX = 3'd7
    } op_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAP,
        S_ACC_LAST,
        S_MIX,
        S_STORE
    } state_t;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        op_sel_t sel;
        logic    acc_en;
        logic    acc_sub;
        logic    store;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    localparam coef_t COEF_RESET [NumCoefs] = '{
        16'sd3064, -16'sd9191, 16'sd9191, -16'sd3064,
        -16'sd2359, 16'sd5551, -16'sd215
    };

endpackage

// File: src/iir3_if.sv
interface iir3_in_if import iir3_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t sample_in;
    sample_t carrier;

    modport source (output valid, output sample_in, output carrier, input ready);
    modport sink   (input valid, input sample_in, input carrier, output ready);
endinterface

interface iir3_out_if import iir3_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t mixed_out;

    modport source (output valid, output mixed_out, input ready);
    modport sink   (input valid, input mixed_out, output ready);
endinterface

// File: src/iir3_filter_mixer_q14.sv
// Channel   Dir  Fields                    Handshake
// in_ch     in   sample_in[16], carrier[16] valid/ready
// out_ch    out  mixed_out[16]              valid/ready
// cfg       in   cfg_index[3], cfg_data[16] cfg_we, no stall
//
// One shared 16x16 multiplier does seven filter taps and the mix: the next
// item is accepted only after the last one is stored, which waits while out_ch is not free.
// The output register holds a finished item while the next one is computed;
// a stalled out_ch holds the controller at its store step.
// Reset clears both histories and loads the default coefficients.
module iir3_filter_mixer_q14
    import iir3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    iir3_in_if.sink                in_ch,
    iir3_out_if.source             out_ch,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgDatWidth-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    iir3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    iir3_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .sample_in (in_ch.sample_in),
        .carrier   (in_ch.carrier),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .mixed_out (out_ch.mixed_out)
    );

endmodule

// File: src/iir3_ctrl.sv
module iir3_ctrl
    import iir3_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.sel     = SEL_B0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_TAP;
                end
            end
            S_TAP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.sel     = op_sel_t'(step_reg);
                cmd.acc_en  = (step_reg != 3'd0);
                cmd.acc_sub = (step_reg >= 3'd5);
                if (step_reg == 3'd6)
                    state_next = S_ACC_LAST;
                else
                    step_next = step_reg + 3'd1;
            end
            S_ACC_LAST:
            begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sub = 1'b1;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.mul_en = 1'b1;
                cmd.sel    = SEL_MIX;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                if (status.out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAP |-> step_reg <= 3'd6)
        else $error("tap step out of range");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_TAP && step_reg == 3'd0)
        else $error("load did not start the tap sequence");

    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> status.out_free && state_reg == S_STORE)
        else $error("store into a full output register");

endmodule

// File: src/iir3_dp.sv
module iir3_dp
    import iir3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  sample_t                sample_in,
    input  sample_t                carrier,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgDatWidth-1:0] cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output sample_t                mixed_out
);

    coef_t   coef_reg [NumCoefs];
    sample_t xh_reg [3];
    sample_t yh_reg [3];
    sample_t x_reg;
    sample_t c_reg;
    sample_t acc_reg;
    sample_t acc_next;
    prod_t   prod_reg;
    sample_t mixed_reg;
    logic    out_valid_reg;
    sample_t op_a;
    sample_t op_b;
    sample_t term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NumCoefs; i++)
                coef_reg[i] <= COEF_RESET[i];
        end
        else if (cfg_we && cfg_index <= CfgIdxWidth'(REG_A3))
        begin
            coef_reg[cfg_index] <= coef_t'(cfg_data);
        end
    end

    always_comb
    begin
        op_a = coef_reg[0];
        op_b = x_reg;
        unique case (cmd.sel)
            SEL_B0:  begin op_a = coef_reg[0]; op_b = x_reg;     end
            SEL_B1:  begin op_a = coef_reg[1]; op_b = xh_reg[0]; end
            SEL_B2:  begin op_a = coef_reg[2]; op_b = xh_reg[1]; end
            SEL_B3:  begin op_a = coef_reg[3]; op_b = xh_reg[2]; end
            SEL_A1:  begin op_a = coef_reg[4]; op_b = yh_reg[0]; end
            SEL_A2:  begin op_a = coef_reg[5]; op_b = yh_reg[1]; end
            SEL_A3:  begin op_a = coef_reg[6]; op_b = yh_reg[2]; end
            SEL_MIX: begin op_a = acc_reg;     op_b = c_reg;     end
            default: begin op_a = coef_reg[0]; op_b = x_reg;     end
        endcase
    end

    assign term     = prod_reg[QShift+SampleWidth-1:QShift];
    assign acc_next = cmd.acc_sub ? acc_reg - term : acc_reg + term;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= sample_in;
            c_reg   <= carrier;
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.mul_en)
            prod_reg <= op_a * op_b;
        if (cmd.store)
            mixed_reg <= prod_reg[MixShift+SampleWidth-1:MixShift];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                xh_reg[i] <= '0;
                yh_reg[i] <= '0;
            end
        end
        else if (cmd.store)
        begin
            xh_reg[2] <= xh_reg[1];
            xh_reg[1] <= xh_reg[0];
            xh_reg[0] <= x_reg;
            yh_reg[2] <= yh_reg[1];
            yh_reg[1] <= yh_reg[0];
            yh_reg[0] <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.store)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign mixed_out       = mixed_reg;

    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |=> out_valid_reg)
        else $error("stored item not presented");

    a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.store |=> $stable(yh_reg[0]) && $stable(xh_reg[0]))
        else $error("history moved without a store");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.mul_en && !cmd.acc_en && !cmd.store)
        else $error("load overlaps datapath work");

endmodule

// File: tb/tb_top.sv
module tb_top;
    import iir3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 300000;
    localparam int SettleCycles = 24;
    localparam int HoldOff      = 200;
    localparam int PhaseItems   = 215;
    localparam int ReportMax    = 10;

    localparam logic [CfgIdxWidth-1:0] RegNone = 3'd7;
    localparam reg_idx_t CoefRegs [NumCoefs] = '{
        REG_B0, REG_B1, REG_B2, REG_B3, REG_A1, REG_A2, REG_A3
    };

    typedef enum int {
        SET_MAX,
        SET_MIN,
        SET_ZERO,
        SET_FIR,
        SET_RANDOM,
        SET_DEFAULT
    } setting_t;

    typedef struct packed {
        sample_t x;
        sample_t c;
        logic    typed;
        sample_t want;
    } probe_t;

    localparam int NumProbes = 18;
    localparam probe_t Probes [NumProbes] = '{
        '{16'sd16384,  16'sd4096,   1'b1, 16'sd3064},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0},
        '{16'sd32767,  16'sd32767,  1'b0, 16'sd0},
        '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
        '{16'sd32767,  -16'sd32768, 1'b0, 16'sd0},
        '{-16'sd32768, 16'sd32767,  1'b0, 16'sd0},
        '{16'sd32767,  16'sd4096,   1'b0, 16'sd0},
        '{-16'sd32768, -16'sd4096,  1'b0, 16'sd0},
        '{16'sd1,      16'sd1,      1'b0, 16'sd0},
        '{-16'sd1,     -16'sd1,     1'b0, 16'sd0},
        '{16'sd0,      16'sd32767,  1'b0, 16'sd0},
        '{16'sd12345,  -16'sd32768, 1'b0, 16'sd0},
        '{-16'sd1,     16'sd32767,  1'b0, 16'sd0},
        '{16'sd21845,  -16'sd21846, 1'b0, 16'sd0},
        '{-16'sd21846, 16'sd21845,  1'b0, 16'sd0},
        '{16'sd0,      16'sd0,      1'b0, 16'sd0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CfgIdxWidth-1:0] cfg_index;
    logic [CfgDatWidth-1:0] cfg_data;

    iir3_in_if  in_ch ();
    iir3_out_if out_ch ();

    iir3_filter_mixer_q14 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    coef_t   coef_q [NumCoefs];
    sample_t x_hist [3];
    sample_t y_hist [3];
    sample_t expected_mix [$];
    int      errors;
    int      cycle_count;
    bit      steady;
    bit      hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic sample_t filter_mix(sample_t x, sample_t c);
        sample_t taps [4];
        longint  acc;
        sample_t y;
        int      k;
        taps[0] = x;
        taps[1] = x_hist[0];
        taps[2] = x_hist[1];
        taps[3] = x_hist[2];
        acc = 0;
        for (k = 0; k < 4; k++)
        begin
            acc += (longint'(coef_q[k]) * longint'(taps[k])) >>> QShift;
        end
        for (k = 0; k < 3; k++)
        begin
            acc -= (longint'(coef_q[4 + k]) * longint'(y_hist[k])) >>> QShift;
        end
        y = sample_t'(acc);
        x_hist[2] = x_hist[1];
        x_hist[1] = x_hist[0];
        x_hist[0] = x;
        y_hist[2] = y_hist[1];
        y_hist[1] = y_hist[0];
        y_hist[0] = y;
        return sample_t'((longint'(y) * longint'(c)) >>> MixShift);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return sample_t'(int'($urandom_range(0, 200)) - 100);
            default: return sample_t'($urandom);
        endcase
    endfunction

    task automatic push_item(sample_t x, sample_t c, logic typed, sample_t want);
        sample_t mix;
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= x;
        in_ch.carrier   <= c;
        do @(posedge clk); while (!in_ch.ready);
        mix = filter_mix(x, c);
        expected_mix.push_back(typed ? want : mix);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_mix.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic load_coefs(setting_t kind);
        coef_t vals [NumCoefs];
        int    i;
        for (i = 0; i < NumCoefs; i++)
        begin
            case (kind)
                SET_MAX:     vals[i] = 16'sh7fff;
                SET_MIN:     vals[i] = 16'sh8000;
                SET_ZERO:    vals[i] = '0;
                SET_FIR:     vals[i] = (i < 4) ? rand_sample() : coef_t'(0);
                SET_DEFAULT: vals[i] = COEF_RESET[i];
                default:     vals[i] = rand_sample();
            endcase
        end
        for (i = 0; i < NumCoefs; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CoefRegs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            coef_q[i] = vals[i];
        end
        // unmapped index: must leave every tap untouched
        cfg_index <= RegNone;
        cfg_data  <= CfgDatWidth'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_result(sample_t got);
        sample_t want;
        if (expected_mix.size() == 0)
        begin
            errors++;
            if (errors <= ReportMax)
                $display("mixed_out %0d arrived with no item pending", got);
        end
        else
        begin
            want = expected_mix.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= ReportMax)
                    $display("mixed_out mismatch: expected %0d, got %0d", want, got);
            end
        end
    endtask

    initial
    begin
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.mixed_out);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req     = 1'b0;
                stall_left   = HoldOff - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 4) == 0)
            begin
                stall_left   = $urandom_range(1, 3) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        setting_t plan [9];
        int       p;
        int       n;
        plan = '{SET_MAX, SET_MIN, SET_ZERO, SET_FIR, SET_RANDOM,
                 SET_RANDOM, SET_RANDOM, SET_RANDOM, SET_DEFAULT};
        errors          = 0;
        steady          = 1'b0;
        hold_req        = 1'b0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.sample_in = '0;
        in_ch.carrier   = '0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        for (n = 0; n < NumCoefs; n++)
            coef_q[n] = COEF_RESET[n];
        for (n = 0; n < 3; n++)
        begin
            x_hist[n] = '0;
            y_hist[n] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NumProbes; n++)
            push_item(Probes[n].x, Probes[n].c, Probes[n].typed, Probes[n].want);
        drain_results();

        for (p = 0; p < 9; p++)
        begin
            load_coefs(plan[p]);
            if (p == 8)
                steady = 1'b1;
            for (n = 0; n < PhaseItems; n++)
            begin
                // fill the block against a long output stall
                if (p == 5 && n == 40)
                    hold_req = 1'b1;
                if (p == 3 && n == 100)
                    drain_results();
                push_item(rand_sample(), rand_sample(), 1'b0, '0);
            end
            drain_results();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
